// ===== src/ames_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the edge store.
`timescale 1ns / 1ps
`default_nettype none

package ames_pkg;

    // Store geometry.
    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_BITS  = 32;
    localparam int SLOTS        = MAX_VERTICES * MAX_VERTICES;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int VIDX_W       = 4;
    localparam int CNT_W        = 5;
    localparam int REQ_W        = 3;
    localparam int STS_W        = 2;
    localparam int OUT_W        = 32;

    // Highest usable vertex count: bounded by the store and by the 4-bit indices.
    localparam int EFF_MAX = (MAX_VERTICES < (1 << VIDX_W)) ? MAX_VERTICES : (1 << VIDX_W);

    // Reset value of the vertex count register.
    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(16);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEL   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SUCC  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PRED  = 3'd4;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_ERR  = 2'd1;
    localparam logic [STS_W-1:0] STS_NONE = 2'd2;

    // Result emit selections driven by the controller.
    localparam logic [2:0] EMIT_NONE   = 3'd0;
    localparam logic [2:0] EMIT_ERR    = 3'd1;
    localparam logic [2:0] EMIT_OK     = 3'd2;
    localparam logic [2:0] EMIT_NOEDGE = 3'd3;
    localparam logic [2:0] EMIT_QUERY  = 3'd4;
    localparam logic [2:0] EMIT_PEND   = 3'd5;
    localparam logic [2:0] EMIT_FINAL  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        logic       set_edge;
        logic       clr_edge;
        logic       mem_rd;
        logic       scan_init;
        logic       scan_step;
        logic [2:0] emit;
    } ames_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             bad;
        logic             slot_present;
        logic             scan_hit;
        logic             scan_last;
        logic             pend_valid;
    } ames_sts_t;

endpackage

`default_nettype wire

// ===== src/ames_datapath.sv =====
// Datapath: request latch, edge valid bits, weight memory, scan counter and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ames_datapath
    import ames_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [VIDX_W-1:0] source_vertex,
    input  wire logic [VIDX_W-1:0] target_vertex,
    input  wire logic [31:0]       edge_weight_in,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    input  wire ames_cmd_t         cmd,
    output ames_sts_t              sts,
    output logic                   result_valid,
    output logic [STS_W-1:0]       status,
    output logic [OUT_W-1:0]       weight_out,
    output logic [VIDX_W-1:0]      neighbor_index,
    output logic                   last_result
);

    logic [REQ_W-1:0]       req_reg;
    logic [VIDX_W-1:0]      src_reg;
    logic [VIDX_W-1:0]      tgt_reg;
    logic [WEIGHT_BITS-1:0] wt_reg;
    logic [CNT_W-1:0]       vcount_reg;
    logic [SLOTS-1:0]       present_reg;
    logic [WEIGHT_BITS-1:0] weight_mem [SLOTS];
    logic [WEIGHT_BITS-1:0] rdata_reg;
    logic [VIDX_W-1:0]      scan_idx_reg;
    logic                   pend_valid_reg;
    logic [VIDX_W-1:0]      pend_idx_reg;
    logic                   strobe_reg;
    logic [STS_W-1:0]       status_reg;
    logic [OUT_W-1:0]       weight_reg;
    logic [VIDX_W-1:0]      nidx_reg;
    logic                   last_reg;

    logic [CNT_W-1:0]  eff_count;
    logic              src_bad;
    logic              tgt_bad;
    logic [SLOT_W-1:0] edge_slot;
    logic [SLOT_W-1:0] scan_slot;

    // Effective vertex count and range checks of the latched request.
    always_comb
    begin
        eff_count = (vcount_reg > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : vcount_reg;
        src_bad   = CNT_W'(src_reg) >= eff_count;
        tgt_bad   = CNT_W'(tgt_reg) >= eff_count;
    end

    // Slot addresses for single-edge requests and for the current scan position.
    always_comb
    begin
        edge_slot = SLOT_W'(src_reg) * SLOT_W'(MAX_VERTICES) + SLOT_W'(tgt_reg);
        if (req_reg == REQ_SUCC)
        begin
            scan_slot = SLOT_W'(src_reg) * SLOT_W'(MAX_VERTICES) + SLOT_W'(scan_idx_reg);
        end
        else
        begin
            scan_slot = SLOT_W'(scan_idx_reg) * SLOT_W'(MAX_VERTICES) + SLOT_W'(tgt_reg);
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.req          = req_reg;
        sts.slot_present = present_reg[edge_slot];
        sts.scan_hit     = present_reg[scan_slot];
        sts.scan_last    = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == eff_count;
        sts.pend_valid   = pend_valid_reg;
        case (req_reg)
            REQ_ADD, REQ_DEL, REQ_QUERY: sts.bad = src_bad || tgt_bad;
            REQ_SUCC:                    sts.bad = src_bad;
            REQ_PRED:                    sts.bad = tgt_bad;
            default:                     sts.bad = 1'b1;
        endcase
    end

    // Request latch; the payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_type;
            src_reg <= source_vertex;
            tgt_reg <= target_vertex;
            wt_reg  <= edge_weight_in;
        end
    end

    // Configuration register and edge valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg  <= VCOUNT_RESET;
            present_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            if (cmd.set_edge)
            begin
                present_reg[edge_slot] <= 1'b1;
            end
            else if (cmd.clr_edge)
            begin
                present_reg[edge_slot] <= 1'b0;
            end
        end
    end

    // Weight memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.set_edge)
        begin
            weight_mem[edge_slot] <= wt_reg;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= weight_mem[edge_slot];
        end
    end

    // Scan counter and the one held match whose last flag is still unknown.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + VIDX_W'(1);
            if (sts.scan_hit)
            begin
                pend_valid_reg <= 1'b1;
                pend_idx_reg   <= scan_idx_reg;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit != EMIT_NONE;
        end
    end

    // Result payload, formed from the emit selection.
    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            EMIT_ERR:
            begin
                status_reg <= STS_ERR;
                weight_reg <= '0;
                nidx_reg   <= '0;
                last_reg   <= 1'b1;
            end
            EMIT_OK:
            begin
                status_reg <= STS_OK;
                weight_reg <= '0;
                nidx_reg   <= '0;
                last_reg   <= 1'b1;
            end
            EMIT_NOEDGE:
            begin
                status_reg <= STS_NONE;
                weight_reg <= '0;
                nidx_reg   <= '0;
                last_reg   <= 1'b1;
            end
            EMIT_QUERY:
            begin
                status_reg <= STS_OK;
                weight_reg <= rdata_reg;
                nidx_reg   <= '0;
                last_reg   <= 1'b1;
            end
            EMIT_PEND:
            begin
                status_reg <= STS_OK;
                weight_reg <= '0;
                nidx_reg   <= pend_idx_reg;
                last_reg   <= 1'b0;
            end
            EMIT_FINAL:
            begin
                status_reg <= pend_valid_reg ? STS_OK : STS_NONE;
                weight_reg <= '0;
                nidx_reg   <= pend_valid_reg ? pend_idx_reg : '0;
                last_reg   <= 1'b1;
            end
            default:
            begin
                status_reg <= status_reg;
                weight_reg <= weight_reg;
                nidx_reg   <= nidx_reg;
                last_reg   <= last_reg;
            end
        endcase
    end

    assign result_valid   = strobe_reg;
    assign status         = status_reg;
    assign weight_out     = weight_reg;
    assign neighbor_index = nidx_reg;
    assign last_result    = last_reg;

endmodule

`default_nettype wire

// ===== src/ames_ctrl.sv =====
// Controller state machine: sequences decode, edge update, weight read and scans.
`timescale 1ns / 1ps
`default_nettype none

module ames_ctrl
    import ames_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire ames_sts_t sts,
    output ames_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_QUERY  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FINAL  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (sts.bad)
                begin
                    cmd.emit = EMIT_ERR;
                end
                else
                begin
                    case (sts.req)
                        REQ_ADD:
                        begin
                            if (sts.slot_present)
                            begin
                                cmd.emit = EMIT_ERR;
                            end
                            else
                            begin
                                cmd.set_edge = 1'b1;
                                cmd.emit     = EMIT_OK;
                            end
                        end
                        REQ_DEL:
                        begin
                            if (sts.slot_present)
                            begin
                                cmd.clr_edge = 1'b1;
                                cmd.emit     = EMIT_OK;
                            end
                            else
                            begin
                                cmd.emit = EMIT_ERR;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (sts.slot_present)
                            begin
                                cmd.mem_rd = 1'b1;
                                state_next = ST_QUERY;
                            end
                            else
                            begin
                                cmd.emit = EMIT_NOEDGE;
                            end
                        end
                        REQ_SUCC, REQ_PRED:
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            cmd.emit = EMIT_ERR;
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                cmd.emit   = EMIT_QUERY;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // A new match releases the previous one, which is then known not to be last.
                cmd.scan_step = 1'b1;
                if (sts.scan_hit && sts.pend_valid)
                begin
                    cmd.emit = EMIT_PEND;
                end
                if (sts.scan_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.emit   = EMIT_FINAL;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;

    // An accepted item always moves the controller into decode.
    a_start_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_DECODE)
        else $error("accepted item did not enter decode");

    // No result is produced while idle.
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> cmd.emit == EMIT_NONE)
        else $error("result emitted while idle");

    // An add only writes a slot that holds no edge.
    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_edge |-> !sts.slot_present)
        else $error("add overwrote an existing edge");

    // The final scan result is followed by idle.
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |=> state_reg == ST_IDLE)
        else $error("scan did not finish after its final result");

    // Held-off matches are only released during a scan.
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit == EMIT_PEND) |-> (state_reg == ST_SCAN && sts.pend_valid))
        else $error("pending match released outside a scan");

endmodule

`default_nettype wire

// ===== src/adjacency_matrix_edge_store.sv =====
// Top level of the directed weighted graph edge store.
`timescale 1ns / 1ps
`default_nettype none

// A request item is taken when start is high and busy is low. Add, delete and
// a query that finds no edge (or any error) give one result, formed in the
// decode state; a query that finds an edge gives its weight from the query
// state, since the weight memory read is registered. Successor and predecessor
// scans read one slot per cycle over the configured vertex count N and deliver
// their last result from the final state after the scan; the matches come in
// ascending order, one per cycle at most, and the receiver cannot stall, so
// every result must be taken in the cycle its strobe is high. busy drops in
// the cycle the final result is on the ports, and a new item may start then.
// The user must write vertex_count only while busy is low; the block does not
// enforce it. The edge store clears at reset.
module adjacency_matrix_edge_store
    import ames_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [VIDX_W-1:0] source_vertex,
    input  wire logic [VIDX_W-1:0] target_vertex,
    input  wire logic [31:0]       edge_weight_in,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    output logic                   result_valid,
    output logic [STS_W-1:0]       status,
    output logic [OUT_W-1:0]       weight_out,
    output logic [VIDX_W-1:0]      neighbor_index,
    output logic                   last_result
);

    ames_cmd_t cmd;
    ames_sts_t sts;

    // Request sequencing.
    ames_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Storage and result formation.
    ames_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req_type),
        .source_vertex  (source_vertex),
        .target_vertex  (target_vertex),
        .edge_weight_in (edge_weight_in),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .sts            (sts),
        .result_valid   (result_valid),
        .status         (status),
        .weight_out     (weight_out),
        .neighbor_index (neighbor_index),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire

// ===== verif/tb_adjacency_matrix_edge_store.sv =====
// Self-checking testbench for the adjacency matrix edge store.
`timescale 1ns / 1ps

module tb_adjacency_matrix_edge_store;
    import ames_pkg::*;

    // One pending operation: either a request item or a vertex count write.
    typedef struct {
        bit                  is_cfg;
        logic [CNT_W-1:0]    cfg_value;
        logic [REQ_W-1:0]    req;
        logic [VIDX_W-1:0]   src;
        logic [VIDX_W-1:0]   tgt;
        logic [31:0]         weight;
    } graph_op_t;

    // One predicted result of a request.
    typedef struct {
        logic [STS_W-1:0]  status;
        logic [OUT_W-1:0]  weight;
        logic [VIDX_W-1:0] neighbor;
        logic              last;
    } graph_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [REQ_W-1:0]    req_type = REQ_ADD;
    logic [VIDX_W-1:0]   source_vertex = '0;
    logic [VIDX_W-1:0]   target_vertex = '0;
    logic [31:0]         edge_weight_in = '0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = VCOUNT_RESET;
    logic                busy;
    logic                result_valid;
    logic [STS_W-1:0]    status;
    logic [OUT_W-1:0]    weight_out;
    logic [VIDX_W-1:0]   neighbor_index;
    logic                last_result;

    // Pending operations, predicted results and the shadow graph.
    graph_op_t           pending_ops[$];
    graph_result_t       awaited_results[$];
    bit                  edge_valid[MAX_VERTICES][MAX_VERTICES];
    logic [31:0]         edge_wt[MAX_VERTICES][MAX_VERTICES];
    logic [CNT_W-1:0]    vertex_limit = VCOUNT_RESET;
    graph_op_t           current_op;
    int                  gap_left = 0;
    int                  steady_left = 0;
    int                  error_count = 0;

    adjacency_matrix_edge_store uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .source_vertex  (source_vertex),
        .target_vertex  (target_vertex),
        .edge_weight_in (edge_weight_in),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .result_valid   (result_valid),
        .status         (status),
        .weight_out     (weight_out),
        .neighbor_index (neighbor_index),
        .last_result    (last_result)
    );

    always #5 clk = ~clk;

    // Queue one predicted result.
    task automatic await_result(input logic [STS_W-1:0] sts, input logic [OUT_W-1:0] wt,
                                input logic [VIDX_W-1:0] idx, input logic last);
        graph_result_t r;
        r.status   = sts;
        r.weight   = wt;
        r.neighbor = idx;
        r.last     = last;
        awaited_results.push_back(r);
    endtask

    // Apply one accepted request to the shadow graph and predict its results.
    task automatic predict_graph_request(input graph_op_t op);
        int n;
        int fixed;
        int last_hit;
        bit by_row;
        bit hit;
        n = (int'(vertex_limit) > EFF_MAX) ? EFF_MAX : int'(vertex_limit);
        if (op.req == REQ_SUCC || op.req == REQ_PRED) begin
            by_row = (op.req == REQ_SUCC);
            fixed = by_row ? int'(op.src) : int'(op.tgt);
            if (fixed >= n) begin
                await_result(STS_ERR, '0, '0, 1'b1);
            end
            else begin
                // Find the final match first so that it carries the last flag.
                last_hit = -1;
                for (int i = 0; i < n; i++) begin
                    hit = by_row ? edge_valid[fixed][i] : edge_valid[i][fixed];
                    if (hit)
                        last_hit = i;
                end
                if (last_hit < 0)
                    await_result(STS_NONE, '0, '0, 1'b1);
                for (int i = 0; i <= last_hit; i++) begin
                    hit = by_row ? edge_valid[fixed][i] : edge_valid[i][fixed];
                    if (hit)
                        await_result(STS_OK, '0, VIDX_W'(i), i == last_hit);
                end
            end
        end
        else if (op.req > REQ_PRED || int'(op.src) >= n || int'(op.tgt) >= n) begin
            await_result(STS_ERR, '0, '0, 1'b1);
        end
        else if (op.req == REQ_ADD) begin
            if (edge_valid[op.src][op.tgt]) begin
                await_result(STS_ERR, '0, '0, 1'b1);
            end
            else begin
                edge_valid[op.src][op.tgt] = 1'b1;
                edge_wt[op.src][op.tgt] = op.weight;
                await_result(STS_OK, '0, '0, 1'b1);
            end
        end
        else if (op.req == REQ_DEL) begin
            if (edge_valid[op.src][op.tgt]) begin
                edge_valid[op.src][op.tgt] = 1'b0;
                await_result(STS_OK, '0, '0, 1'b1);
            end
            else begin
                await_result(STS_ERR, '0, '0, 1'b1);
            end
        end
        else if (edge_valid[op.src][op.tgt]) begin
            await_result(STS_OK, edge_wt[op.src][op.tgt], '0, 1'b1);
        end
        else begin
            await_result(STS_NONE, '0, '0, 1'b1);
        end
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [VIDX_W-1:0] src,
                                 input logic [VIDX_W-1:0] tgt, input logic [31:0] wt);
        graph_op_t op;
        op.is_cfg    = 1'b0;
        op.cfg_value = '0;
        op.req       = req;
        op.src       = src;
        op.tgt       = tgt;
        op.weight    = wt;
        pending_ops.push_back(op);
    endtask

    task automatic queue_count_write(input logic [CNT_W-1:0] value);
        graph_op_t op;
        op.is_cfg    = 1'b1;
        op.cfg_value = value;
        op.req       = REQ_ADD;
        op.src       = '0;
        op.tgt       = '0;
        op.weight    = '0;
        pending_ops.push_back(op);
    endtask

    // Vertex choice: mostly in range, often a small subset to force collisions.
    function automatic logic [VIDX_W-1:0] pick_vertex(input int n);
        int r;
        r = $urandom_range(0, 9);
        if (n == 0 || r == 0)
            return VIDX_W'($urandom_range(0, (1 << VIDX_W) - 1));
        if (r < 4)
            return VIDX_W'($urandom_range(0, ((n < 4) ? n : 4) - 1));
        return VIDX_W'($urandom_range(0, n - 1));
    endfunction

    // Request driver: issues queued operations with random gaps.
    always @(posedge clk or negedge rst_n) begin
        logic start_next;
        logic cfg_next;
        bit   idle;
        if (!rst_n) begin
            start          <= 1'b0;
            cfg_wr_en      <= 1'b0;
            cfg_wr_data    <= VCOUNT_RESET;
            req_type       <= REQ_ADD;
            source_vertex  <= '0;
            target_vertex  <= '0;
            edge_weight_in <= '0;
            gap_left       = 0;
        end
        else begin
            start_next = start;
            cfg_next   = 1'b0;
            idle = awaited_results.size() == 0 && !result_valid && !busy && !start;
            if (start && !busy) begin
                predict_graph_request(current_op);
                start_next = 1'b0;
                // Mix random gaps with stretches of back-to-back items.
                if (steady_left > 0) begin
                    steady_left--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 9) == 0) begin
                    steady_left = $urandom_range(5, 15);
                    gap_left = 0;
                end
                else begin
                    gap_left = $urandom_range(0, 11);
                end
            end
            if (!start_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (pending_ops.size() != 0) begin
                    if (pending_ops[0].is_cfg) begin
                        // Count writes go in only once every result has come back.
                        if (idle) begin
                            cfg_next = 1'b1;
                            cfg_wr_data <= pending_ops[0].cfg_value;
                            vertex_limit = pending_ops[0].cfg_value;
                            void'(pending_ops.pop_front());
                        end
                    end
                    else begin
                        current_op = pending_ops.pop_front();
                        req_type       <= current_op.req;
                        source_vertex  <= current_op.src;
                        target_vertex  <= current_op.tgt;
                        edge_weight_in <= current_op.weight;
                        start_next = 1'b1;
                    end
                end
            end
            start     <= start_next;
            cfg_wr_en <= cfg_next;
        end
    end

    // Result monitor: every strobed result is matched against the oldest prediction.
    always @(posedge clk) begin
        graph_result_t exp_r;
        if (rst_n && result_valid) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d weight=%h index=%0d last=%0b",
                         $time, status, weight_out, neighbor_index, last_result);
                error_count++;
            end
            else begin
                exp_r = awaited_results.pop_front();
                if (status !== exp_r.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, exp_r.status, status);
                    error_count++;
                end
                if (weight_out !== exp_r.weight) begin
                    $display("%0t: weight_out mismatch expected %h actual %h",
                             $time, exp_r.weight, weight_out);
                    error_count++;
                end
                if (neighbor_index !== exp_r.neighbor) begin
                    $display("%0t: neighbor_index mismatch expected %0d actual %0d",
                             $time, exp_r.neighbor, neighbor_index);
                    error_count++;
                end
                if (last_result !== exp_r.last) begin
                    $display("%0t: last_result mismatch expected %0b actual %0b",
                             $time, exp_r.last, last_result);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and end of test.
    initial begin
        logic [CNT_W-1:0] phase_counts[8];
        int               n;
        int               items;
        int               r;
        logic [REQ_W-1:0] req;
        logic [31:0]      wt;
        phase_counts = '{CNT_W'(16), CNT_W'(3), CNT_W'(1), CNT_W'(31),
                         CNT_W'(2), CNT_W'(0), CNT_W'(5), CNT_W'(16)};

        // Directed part: empty graph, corner vertices, duplicates and absent edges.
        queue_request(REQ_QUERY, 4'd0, 4'd0, 32'h0);
        queue_request(REQ_SUCC, 4'd0, 4'd9, 32'h0);
        queue_request(REQ_PRED, 4'd3, 4'd15, 32'h0);
        queue_request(REQ_ADD, 4'd0, 4'd0, 32'h0000_0000);
        queue_request(REQ_ADD, 4'd15, 4'd15, 32'hFFFF_FFFF);
        queue_request(REQ_ADD, 4'd0, 4'd15, 32'hA5A5_A5A5);
        queue_request(REQ_ADD, 4'd15, 4'd0, 32'h5A5A_5A5A);
        queue_request(REQ_ADD, 4'd0, 4'd0, 32'h1234_5678);
        queue_request(REQ_QUERY, 4'd0, 4'd0, 32'hFFFF_FFFF);
        queue_request(REQ_QUERY, 4'd15, 4'd15, 32'h0);
        queue_request(REQ_SUCC, 4'd0, 4'd15, 32'h0);
        queue_request(REQ_PRED, 4'd15, 4'd0, 32'h0);
        queue_request(REQ_SUCC, 4'd15, 4'd15, 32'h0);
        queue_request(REQ_PRED, 4'd15, 4'd15, 32'h0);
        queue_request(REQ_DEL, 4'd0, 4'd0, 32'h0);
        queue_request(REQ_DEL, 4'd0, 4'd0, 32'h0);
        // Undefined request codes above the predecessor scan.
        for (int k = 1; REQ_PRED + k <= {REQ_W{1'b1}}; k++)
            queue_request(REQ_W'(REQ_PRED + k), 4'd15, 4'd15, 32'hFFFF_FFFF);
        // A single vertex: anything touching vertex 1 is out of range.
        queue_count_write(CNT_W'(1));
        queue_request(REQ_SUCC, 4'd0, 4'd15, 32'h0);
        queue_request(REQ_ADD, 4'd0, 4'd1, 32'h0);
        queue_request(REQ_PRED, 4'd15, 4'd0, 32'h0);
        queue_request(REQ_QUERY, 4'd1, 4'd0, 32'h0);
        // A zero count makes every request an error.
        queue_count_write(CNT_W'(0));
        queue_request(REQ_SUCC, 4'd0, 4'd0, 32'h0);
        queue_request(REQ_QUERY, 4'd0, 4'd0, 32'h0);
        // Counts above the store size clamp to it and keep the stored edges.
        queue_count_write({CNT_W{1'b1}});
        queue_request(REQ_QUERY, 4'd15, 4'd15, 32'h0);

        // Random part: phases at different vertex counts.
        foreach (phase_counts[p]) begin
            queue_count_write(phase_counts[p]);
            n = (int'(phase_counts[p]) > EFF_MAX) ? EFF_MAX : int'(phase_counts[p]);
            items = (n == 0) ? 4 : 12;
            for (int i = 0; i < items; i++) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    req = REQ_ADD;
                else if (r < 50)
                    req = REQ_DEL;
                else if (r < 68)
                    req = REQ_QUERY;
                else if (r < 80)
                    req = REQ_SUCC;
                else if (r < 92)
                    req = REQ_PRED;
                else
                    req = REQ_W'($urandom_range(int'(REQ_PRED) + 1, (1 << REQ_W) - 1));
                r = $urandom_range(0, 9);
                if (r == 0)
                    wt = '0;
                else if (r == 1)
                    wt = '1;
                else
                    wt = $urandom;
                queue_request(req, pick_vertex(n), pick_vertex(n), wt);
            end
        end

        // Reset, then run until every operation is issued and answered.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || start || awaited_results.size() != 0);
        repeat (40) @(negedge clk);
        if (awaited_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("adjacency_matrix_edge_store test passed");
        else
            $display("adjacency_matrix_edge_store test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #1_000_000;
        $display("adjacency_matrix_edge_store test failed");
        $finish;
    end

endmodule
